FILE: rtl/core/bhld_pkg.sv
// ----------------------------------------------------------------------------
// bhld_pkg: shared types and constants of the byte histogram level display
// Holds field widths, reset constants and the status struct that the level
// unit hands back to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bhld_pkg;

   localparam int SAMPLE_BITS  = 8;
   localparam int PERIOD_BITS  = 8;
   localparam int LEVEL_BITS   = 3;

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd10;
   localparam logic [PERIOD_BITS-1:0] COUNTER_TOP  = 8'd255;
   localparam logic [LEVEL_BITS-1:0]  LEVEL_TOP    = 3'd6;

   // status of the level unit as seen by the sequencer
   typedef struct packed {
      logic                  done;   // level is final, held until the next start
      logic [LEVEL_BITS-1:0] level;
   } lvl_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/byte_histogram_level_display.sv
// ----------------------------------------------------------------------------
// byte_histogram_level_display: byte histogram with periodic level reports
// Counts sample bytes into NUM_BINS bins by their top bits and, every
// report_period blocks, reports a 0..6 level per bin scaled to the fullest bin.
// ----------------------------------------------------------------------------
// Each req transaction carries one sample byte and a block-start flag. A
// plain sample passes through accept, count read and count write before
// req_ready returns, since the count memory is read through a register
// ahead of its write. A block start advances the block counter (it stops
// at 255); when the counter reaches report_period the counter clears and the
// block walks the bins twice before counting the sample: a max scan with a
// read and a compare per bin, then one level per bin, each taking a read, a
// start, 1 to 7 steps of the shared level unit (one compare and one add per
// step) and a load of the rsp register, which waits while rsp stalls. Levels
// leave on the rsp channel in bin order, last_bin marking the final bin;
// after the last level all bins are cleared at once. The rsp register lets
// a new sample be accepted while the last level still waits. report_period
// and the block counter both reset to 10, so the first block start reports.
// csr writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_histogram_level_display #(
   parameter int NUM_BINS   = 64,
   parameter int COUNT_BITS = 24,
   parameter int BIN_BITS   = $clog2(NUM_BINS)
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [bhld_pkg::SAMPLE_BITS-1:0]     req_sample,
   input  wire logic                                 req_block_start,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [BIN_BITS-1:0]                  rsp_bin_index,
   output logic      [bhld_pkg::LEVEL_BITS-1:0]      rsp_level,
   output logic                                      rsp_last_bin,
   // configuration
   input  wire logic                                 csr_write_enable,
   input  wire logic [bhld_pkg::PERIOD_BITS-1:0]     csr_write_data
);

   localparam int BIN_WIDTH  = 256 / NUM_BINS;
   localparam int STATE_BITS = 3;

   localparam logic [STATE_BITS-1:0] S_IDLE      = 3'd0;
   localparam logic [STATE_BITS-1:0] S_CNT_RD    = 3'd1;
   localparam logic [STATE_BITS-1:0] S_CNT_WR    = 3'd2;
   localparam logic [STATE_BITS-1:0] S_MAX_RD    = 3'd3;
   localparam logic [STATE_BITS-1:0] S_MAX_CMP   = 3'd4;
   localparam logic [STATE_BITS-1:0] S_LVL_RD    = 3'd5;
   localparam logic [STATE_BITS-1:0] S_LVL_START = 3'd6;
   localparam logic [STATE_BITS-1:0] S_LVL_RUN   = 3'd7;

   localparam logic [BIN_BITS-1:0]   LAST_BIN    = BIN_BITS'(NUM_BINS - 1);

   // sample to bin map, clamped where the bin width does not divide 256
   logic [BIN_BITS-1:0] bin_lut [256];

   for (genvar s = 0; s < 256; s++) begin : g_bin_lut
      localparam int QUOT = s / BIN_WIDTH;
      localparam int BIN  = (QUOT > NUM_BINS - 1) ? NUM_BINS - 1 : QUOT;
      assign bin_lut[s] = BIN_BITS'(BIN);
   end

   logic [STATE_BITS-1:0]                  state_ff,   state_in;
   logic [bhld_pkg::PERIOD_BITS-1:0]       period_ff,  period_in;
   logic [bhld_pkg::PERIOD_BITS-1:0]       blocks_ff,  blocks_in;
   logic [BIN_BITS-1:0]                    bin_ff,     bin_in;
   logic [BIN_BITS-1:0]                    idx_ff,     idx_in;
   logic [COUNT_BITS-1:0]                  max_ff,     max_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [BIN_BITS-1:0]                    rsp_bin_ff,   rsp_bin_in;
   logic [bhld_pkg::LEVEL_BITS-1:0]        rsp_level_ff, rsp_level_in;
   logic                                   rsp_last_ff,  rsp_last_in;

   logic                                   req_fire;
   logic                                   out_free;
   logic [bhld_pkg::PERIOD_BITS-1:0]       blocks_sat;
   logic                                   report;
   logic [COUNT_BITS-1:0]                  rd_count;
   logic [COUNT_BITS-1:0]                  count_inc;
   logic [COUNT_BITS-1:0]                  max_eff;
   logic [BIN_BITS-1:0]                    rd_addr;
   logic                                   wr_en;
   logic                                   clear_all;
   logic                                   lvl_start;
   bhld_pkg::lvl_status_type               lvl_status;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // advance the block counter, holding at the top
   assign blocks_sat = (blocks_ff == bhld_pkg::COUNTER_TOP) ? blocks_ff
                                                            : blocks_ff + 1'b1;
   assign report     = req_block_start && (blocks_sat >= period_ff);

   // saturating increment of the bin count
   assign count_inc  = (rd_count == {COUNT_BITS{1'b1}}) ? rd_count : rd_count + 1'b1;

   // an empty histogram scales against one
   assign max_eff    = (max_ff == '0) ? COUNT_BITS'(1) : max_ff;

   assign rd_addr    = (state_ff == S_CNT_RD) ? bin_ff : idx_ff;
   assign wr_en      = (state_ff == S_CNT_WR);
   assign lvl_start  = (state_ff == S_LVL_START);

   always_comb begin
      state_in     = state_ff;
      period_in    = csr_write_enable ? csr_write_data : period_ff;
      blocks_in    = blocks_ff;
      bin_in       = bin_ff;
      idx_in       = idx_ff;
      max_in       = max_ff;
      clear_all    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bin_in   = rsp_bin_ff;
      rsp_level_in = rsp_level_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               bin_in = bin_lut[req_sample];
               if (req_block_start) begin
                  blocks_in = report ? '0 : blocks_sat;
               end
               if (report) begin
                  idx_in   = '0;
                  max_in   = '0;
                  state_in = S_MAX_RD;
               end else begin
                  state_in = S_CNT_RD;
               end
            end
         end
         S_CNT_RD: begin
            state_in = S_CNT_WR;
         end
         S_CNT_WR: begin
            state_in = S_IDLE;
         end
         S_MAX_RD: begin
            state_in = S_MAX_CMP;
         end
         S_MAX_CMP: begin
            if (rd_count > max_ff) begin
               max_in = rd_count;
            end
            if (idx_ff == LAST_BIN) begin
               idx_in   = '0;
               state_in = S_LVL_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_MAX_RD;
            end
         end
         S_LVL_RD: begin
            state_in = S_LVL_START;
         end
         S_LVL_START: begin
            state_in = S_LVL_RUN;
         end
         S_LVL_RUN: begin
            // hold until the level is final and the rsp register has room
            if (lvl_status.done || !rsp_valid_ff || rsp_ready) begin
               if (lvl_status.done && out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_bin_in   = idx_ff;
                  rsp_level_in = lvl_status.level;
                  rsp_last_in  = (idx_ff == LAST_BIN);
                  if (idx_ff == LAST_BIN) begin
                     clear_all = 1'b1;
                     state_in  = S_CNT_RD;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_LVL_RD;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   bhld_count_ram #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS),
      .BIN_BITS   (BIN_BITS)
   ) u_count_ram (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .wr_en     (wr_en),
      .wr_addr   (bin_ff),
      .wr_data   (count_inc),
      .rd_addr   (rd_addr),
      .rd_data   (rd_count)
   );

   bhld_level_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_level_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (lvl_start),
      .count     (rd_count),
      .max_count (max_eff),
      .status    (lvl_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= bhld_pkg::PERIOD_RESET;
         blocks_ff    <= bhld_pkg::PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         blocks_ff    <= blocks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      idx_ff       <= idx_in;
      max_ff       <= max_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_level_ff <= rsp_level_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_last_bin  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bhld_count_ram.sv
// ----------------------------------------------------------------------------
// bhld_count_ram: bin count memory
// One write port, one registered read port; a valid bit per entry makes an
// entry read as zero after reset or after a bulk clear.
// ----------------------------------------------------------------------------
`default_nettype none

module bhld_count_ram #(
   parameter int NUM_BINS   = 64,
   parameter int COUNT_BITS = 24,
   parameter int BIN_BITS   = $clog2(NUM_BINS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear_all,
   input  wire logic                  wr_en,
   input  wire logic [BIN_BITS-1:0]   wr_addr,
   input  wire logic [COUNT_BITS-1:0] wr_data,
   input  wire logic [BIN_BITS-1:0]   rd_addr,
   output logic      [COUNT_BITS-1:0] rd_data
);

   logic [COUNT_BITS-1:0] mem [NUM_BINS];
   logic [NUM_BINS-1:0]   valid_ff;
   logic [NUM_BINS-1:0]   valid_in;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/core/bhld_level_unit.sv
// ----------------------------------------------------------------------------
// bhld_level_unit: iterative level quantizer
// Finds floor((12*count + max) / (2*max)), capped at the top level, by
// stepping a threshold max, 3*max, 5*max ... against 12*count, one compare
// and one add per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bhld_level_unit #(
   parameter int COUNT_BITS = 24
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [COUNT_BITS-1:0]   count,
   input  wire logic [COUNT_BITS-1:0]   max_count,
   output bhld_pkg::lvl_status_type     status
);

   // 12*count and 13*max both fit below 16 * 2^COUNT_BITS
   localparam int ACC_BITS = COUNT_BITS + 4;

   logic [ACC_BITS-1:0]                 tgt_ff,  tgt_in;
   logic [ACC_BITS-1:0]                 thr_ff,  thr_in;
   logic [ACC_BITS-1:0]                 step_ff, step_in;
   logic [bhld_pkg::LEVEL_BITS-1:0]     lvl_ff,  lvl_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [ACC_BITS-1:0]                 count_ext;
   logic [ACC_BITS-1:0]                 max_ext;
   logic                                finish;

   assign count_ext = ACC_BITS'(count);
   assign max_ext   = ACC_BITS'(max_count);
   assign finish    = (lvl_ff == bhld_pkg::LEVEL_TOP) || (tgt_ff < thr_ff);

   always_comb begin
      tgt_in  = tgt_ff;
      thr_in  = thr_ff;
      step_in = step_ff;
      lvl_in  = lvl_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         tgt_in  = (count_ext << 3) + (count_ext << 2);
         thr_in  = max_ext;
         step_in = max_ext << 1;
         lvl_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (finish) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            lvl_in = lvl_ff + 1'b1;
            thr_in = thr_ff + step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff  <= tgt_in;
      thr_ff  <= thr_in;
      step_ff <= step_in;
      lvl_ff  <= lvl_in;
   end

   assign status.done  = done_ff;
   assign status.level = lvl_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bhld_checker.sv
// ----------------------------------------------------------------------------
// bhld_port_checker: port-level checks for the byte histogram level display
// Watches the req and rsp channels of the top level; bound in below.
// ----------------------------------------------------------------------------
`default_nettype none

module bhld_port_checker #(
   parameter int NUM_BINS = 64,
   parameter int BIN_BITS = $clog2(NUM_BINS)
) (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire logic [bhld_pkg::SAMPLE_BITS-1:0]     req_sample,
   input wire logic                                 req_block_start,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [BIN_BITS-1:0]                  rsp_bin_index,
   input wire logic [bhld_pkg::LEVEL_BITS-1:0]      rsp_level,
   input wire logic                                 rsp_last_bin
);

   // a pending req transaction holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_sample)
                                 && $stable(req_block_start))
      else $error("req payload changed while stalled");

   // a pending rsp transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_index)
                                 && $stable(rsp_level) && $stable(rsp_last_bin))
      else $error("rsp payload changed while stalled");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level <= bhld_pkg::LEVEL_TOP)
      else $error("level above top");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bin |-> rsp_bin_index == BIN_BITS'(NUM_BINS - 1))
      else $error("last_bin on a bin other than the final one");

   // no new sample is taken while a report still has bins to deliver
   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_bin |-> !req_ready)
      else $error("req accepted in the middle of a report");

endmodule

bind byte_histogram_level_display bhld_port_checker #(
   .NUM_BINS (NUM_BINS),
   .BIN_BITS (BIN_BITS)
) u_bhld_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_sample      (req_sample),
   .req_block_start (req_block_start),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_bin_index   (rsp_bin_index),
   .rsp_level       (rsp_level),
   .rsp_last_bin    (rsp_last_bin)
);

`default_nettype wire

FILE: bench/bhld_checker.sv
// ----------------------------------------------------------------------------
// bhld_checker: level report predictor and comparator
// Watches the req, rsp and csr ports of the histogram block, keeps its own
// bin counts, block counter and report period, queues the 0..6 level of each
// bin whenever a report is due, and compares every rsp transaction with the
// oldest queued level.
// ----------------------------------------------------------------------------
module bhld_checker #(
   parameter int NUM_BINS   = 64,
   parameter int COUNT_BITS = 24,
   parameter int BIN_BITS   = $clog2(NUM_BINS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [bhld_pkg::SAMPLE_BITS-1:0]     req_sample,
   input  logic                                 req_block_start,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [BIN_BITS-1:0]                  rsp_bin_index,
   input  logic [bhld_pkg::LEVEL_BITS-1:0]      rsp_level,
   input  logic                                 rsp_last_bin,
   input  logic                                 csr_write_enable,
   input  logic [bhld_pkg::PERIOD_BITS-1:0]     csr_write_data,
   output int                                   error_count,
   output int                                   levels_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BIN_SPAN = 256 / NUM_BINS;
   localparam longint unsigned LEVEL_CAP = longint'(bhld_pkg::LEVEL_TOP);

   typedef struct packed {
      logic [BIN_BITS-1:0]             bin;
      logic [bhld_pkg::LEVEL_BITS-1:0] level;
      logic                            last;
   } bin_level_type;

   logic [COUNT_BITS-1:0]            bin_tally [NUM_BINS];
   logic [bhld_pkg::PERIOD_BITS-1:0] blocks_seen;
   logic [bhld_pkg::PERIOD_BITS-1:0] period_shadow;
   bin_level_type                    pending_levels [$];

   initial error_count = 0;
   initial levels_due = 0;

   // round(6*count/peak) in exact integer form
   function automatic logic [bhld_pkg::LEVEL_BITS-1:0] scaled_level(
      input longint unsigned count, input longint unsigned peak);
      longint unsigned q;
      q = (2 * LEVEL_CAP * count + peak) / (2 * peak);
      if (q > LEVEL_CAP) q = LEVEL_CAP;
      return q[bhld_pkg::LEVEL_BITS-1:0];
   endfunction

   task automatic queue_level_report();
      longint unsigned peak;
      bin_level_type   entry;
      peak = 0;
      for (int i = 0; i < NUM_BINS; i++) begin
         if (64'(bin_tally[i]) > peak) peak = 64'(bin_tally[i]);
      end
      if (peak == 0) peak = 1;
      for (int i = 0; i < NUM_BINS; i++) begin
         entry.bin   = BIN_BITS'(i);
         entry.level = scaled_level(64'(bin_tally[i]), peak);
         entry.last  = (i == NUM_BINS - 1);
         pending_levels.push_back(entry);
      end
      for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
      blocks_seen = '0;
   endtask

   always @(posedge clock) begin
      bin_level_type want;
      int            idx;
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
         blocks_seen   = bhld_pkg::PERIOD_RESET;
         period_shadow = bhld_pkg::PERIOD_RESET;
         pending_levels.delete();
      end else begin
         // results first: a level can never leave at the edge that queued it
         if (rsp_valid && rsp_ready) begin
            if (pending_levels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected level, expected none, actual bin %0d level %0d last %0d",
                        $time, rsp_bin_index, rsp_level, rsp_last_bin);
            end else begin
               want = pending_levels.pop_front();
               if (rsp_bin_index !== want.bin) begin
                  error_count++;
                  $display("%0t: bin_index expected %0d, actual %0d",
                           $time, want.bin, rsp_bin_index);
               end
               if (rsp_level !== want.level) begin
                  error_count++;
                  $display("%0t: level of bin %0d expected %0d, actual %0d",
                           $time, want.bin, want.level, rsp_level);
               end
               if (rsp_last_bin !== want.last) begin
                  error_count++;
                  $display("%0t: last_bin of bin %0d expected %0d, actual %0d",
                           $time, want.bin, want.last, rsp_last_bin);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_block_start) begin
               if (blocks_seen < bhld_pkg::COUNTER_TOP) blocks_seen = blocks_seen + 1'b1;
               if (blocks_seen >= period_shadow) queue_level_report();
            end
            idx = int'(req_sample) / BIN_SPAN;
            if (idx > NUM_BINS - 1) idx = NUM_BINS - 1;
            if (bin_tally[idx] != '1) bin_tally[idx] = bin_tally[idx] + 1'b1;
         end
         // a written period takes effect from the next transaction on
         if (csr_write_enable) period_shadow = csr_write_data;
      end
      levels_due = pending_levels.size();
   end

endmodule

FILE: bench/byte_histogram_level_display_tb.sv
// ----------------------------------------------------------------------------
// byte_histogram_level_display_tb: regression bench for the histogram block
// Feeds sample bytes in bursts, with and without block starts, under several
// report periods, while the result side stalls on its own pattern. A checker
// beside the block predicts every level report and counts mismatches.
// ----------------------------------------------------------------------------
module byte_histogram_level_display_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BINS   = 64;
   localparam int COUNT_BITS = 24;
   localparam int BIN_BITS   = $clog2(NUM_BINS);
   localparam int BIN_SPAN   = 256 / NUM_BINS;
   // margin for a plain sample to finish counting after its transaction and
   // for the bin clear after a report to take effect
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_LIMIT   = 200000;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [bhld_pkg::SAMPLE_BITS-1:0]     req_sample = '0;
   logic                                 req_block_start = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [BIN_BITS-1:0]                  rsp_bin_index;
   logic [bhld_pkg::LEVEL_BITS-1:0]      rsp_level;
   logic                                 rsp_last_bin;
   logic                                 csr_write_enable = 1'b0;
   logic [bhld_pkg::PERIOD_BITS-1:0]     csr_write_data = '0;

   int mismatch_count;
   int levels_due;

   // sender burst bookkeeping and result-side stall pattern
   int       burst_left = 1;
   int       stall_tick = 0;
   int       stall_mode = 0;
   int       hot_bin [3];

   // directed warm-up bytes: top bin four times, bin 0 three times (with the
   // first sample), bin 1 twice, a few singles, so the first real report
   // spans several distinct levels
   logic [7:0] warm_bytes [14] = '{8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h00, 8'h01, 8'h04,
                                   8'h07, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h3C, 8'hC3};

   byte_histogram_level_display #(
      .NUM_BINS  (NUM_BINS),
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_level       (rsp_level),
      .rsp_last_bin    (rsp_last_bin),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   bhld_checker #(
      .NUM_BINS  (NUM_BINS),
      .COUNT_BITS(COUNT_BITS)
   ) level_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_level       (rsp_level),
      .rsp_last_bin    (rsp_last_bin),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .error_count     (mismatch_count),
      .levels_due      (levels_due)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stall the result side in modes re-picked at random on a regular tick:
   // always ready, coin flip, mostly stalled, and a fixed on/off square wave.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 256 == 255) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= ($urandom_range(0, 7) == 0);
         end
         default: begin
            rsp_ready <= stall_tick[2];
         end
      endcase
   end

   // Give up on a hung run.
   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Pick a sample byte: uniform, or weighted toward three hot bins so that
   // the report holds a spread of levels rather than only the extremes.
   function automatic logic [7:0] pick_sample(input bit skewed);
      int roll;
      roll = $urandom_range(0, 99);
      if (!skewed || roll >= 60) return 8'($urandom_range(0, 255));
      if (roll < 30) return 8'(hot_bin[0] * BIN_SPAN + $urandom_range(0, BIN_SPAN - 1));
      if (roll < 48) return 8'(hot_bin[1] * BIN_SPAN + $urandom_range(0, BIN_SPAN - 1));
      return 8'(hot_bin[2] * BIN_SPAN + $urandom_range(0, BIN_SPAN - 1));
   endfunction

   // Present one transaction and hold it until accepted. At the end of a
   // burst, drop valid for a random gap (often none) and pick the next length.
   task automatic push_sample(input logic [7:0] value, input logic starts_block);
      int gap;
      req_valid       <= 1'b1;
      req_sample      <= value;
      req_block_start <= starts_block;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Drop valid, wait for every queued level, then let in-flight counting end.
   task automatic quiesce();
      if (req_valid) req_valid <= 1'b0;
      while (levels_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_period(input logic [bhld_pkg::PERIOD_BITS-1:0] period);
      quiesce();
      csr_write_data   <= period;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One phase: set the period, pick fresh hot bins, then send well-formed
   // blocks of a start byte followed by up to max_extra plain bytes.
   task automatic run_blocks(input logic [bhld_pkg::PERIOD_BITS-1:0] period,
                             input int blocks, input int max_extra, input bit skewed);
      int extra;
      write_period(period);
      foreach (hot_bin[k]) hot_bin[k] = $urandom_range(0, NUM_BINS - 1);
      for (int n = 0; n < blocks; n++) begin
         push_sample(pick_sample(skewed), 1'b1);
         extra = $urandom_range(0, max_extra);
         repeat (extra) push_sample(pick_sample(skewed), 1'b0);
      end
   endtask

   initial begin
      int spin;
      // hold reset from the start, release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset period and counter are both 10: the first block start reports
      // an empty histogram, where the peak is taken as one and all levels are 0
      push_sample(8'h00, 1'b1);
      // plain bytes only count, no report
      foreach (warm_bytes[i]) push_sample(warm_bytes[i], 1'b0);
      // period 1: every start reports, back to back
      write_period(8'd1);
      push_sample(8'h40, 1'b1);
      push_sample(8'h41, 1'b1);
      // period 0: still one report per start
      write_period(8'd0);
      push_sample(8'hFF, 1'b1);
      push_sample(8'h00, 1'b0);
      // period 2: first start only advances the counter
      write_period(8'd2);
      push_sample(8'h10, 1'b1);
      push_sample(8'h20, 1'b1);

      // random phases across periods, small to large
      run_blocks(8'd3, 8, 3, 1'b1);
      run_blocks(8'd0, 8, 3, 1'b0);
      run_blocks(8'd2, 8, 3, 1'b1);
      run_blocks(8'($urandom_range(4, 20)), 20, 1, 1'b1);
      run_blocks(8'd1, 8, 3, 1'b1);
      // long period: the counter climbs all the way to 100 before reporting
      run_blocks(8'd100, 100, 0, 1'b0);

      // drain the last report, bounded, then give the verdict
      if (req_valid) req_valid <= 1'b0;
      for (spin = 0; levels_due != 0 && spin < DRAIN_LIMIT; spin++) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && levels_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/bhld_pkg.sv
rtl/core/bhld_count_ram.sv
rtl/core/bhld_level_unit.sv
rtl/core/byte_histogram_level_display.sv
rtl/core/bhld_checker.sv
bench/bhld_checker.sv
bench/byte_histogram_level_display_tb.sv
